[hdl/dpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants of the distance presence trigger
// Field widths, register indexes, reset values and stream packing layout.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DistW   = 13;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned IdW     = 8;
  localparam int unsigned MissW   = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Stream packing widths (tdata widths rounded up to whole bytes).
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned OutUserW = 2;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    REG_NEAR_THRESHOLD  = 3'd0,
    REG_FAR_THRESHOLD   = 3'd1,
    REG_SAMPLE_PERIOD   = 3'd2,
    REG_COOLDOWN        = 3'd3,
    REG_SENSOR_ID       = 3'd4,
    REG_OFFLINE_SILENCE = 3'd5,
    REG_OFFLINE_MISSES  = 3'd6
  } cfg_reg_t;

  // Register reset values.
  localparam logic [ThrW-1:0]  NearReset     = 12'd30;
  localparam logic [ThrW-1:0]  FarReset      = 12'd50;
  localparam logic [TimeW-1:0] PeriodReset   = 32'd100;
  localparam logic [TimeW-1:0] CooldownReset = 32'd2000;

  // Missed-echo counter saturation point and the "no reading yet" pattern.
  localparam logic [MissW-1:0] MissMax     = 16'hFFFF;
  localparam logic [DistW-1:0] NoReading   = 13'h1FFF;

  // Result item, before packing onto the stream.
  typedef struct packed {
    logic              offline;
    logic [TimeW-1:0]  last_valid_time_ms;
    logic [MissW-1:0]  miss_count;
    logic [DistW-1:0]  last_distance_cm;
    logic [IdW-1:0]    event_sensor_id;
    logic [TimeW-1:0]  event_time_ms;
  } result_data_t;

  typedef struct packed {
    logic fired;
    logic sampled;
  } result_user_t;

endpackage : dpt_pkg
`default_nettype wire

[hdl/distance_presence_trigger_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distance_presence_trigger_top: presence detector with hysteresis and hold-off
// Consumes timestamped distance readings and reports presence events.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one transfer per reading: the current millisecond
// time and a signed distance, negative meaning no echo. Each input transfer
// produces exactly one result transfer with the sample and fire flags in
// out_tuser and the event, reading and health status in out_tdata.
// The configuration port writes one register per cycle with cfg_we high; the
// user must write it only while no transfer is in flight, as the block
// itself does not enforce this. An input transfer lands in the input register
// at its accepting edge; the result register loads from it once it is free,
// and out_tvalid then rises. Throughput is one transfer per cycle while
// out_tready stays high; the only loop is the state update, which closes
// through the compare and add logic between the input register and the
// result register.
// When the receiver holds out_tready low, the result register keeps its
// transfer, the input register fills, and in_tready then drops; no transfer
// is lost or repeated. After the synchronous reset (rst_n low) both stages are
// empty, the registers hold their documented defaults and the first reading
// is sampled at once.
// ----------------------------------------------------------------------------
module distance_presence_trigger_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input stream. tdata, lowest bit up: now_ms[31:0], distance_cm[12:0].
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [dpt_pkg::InDataW-1:0]   in_tdata,
  // Result stream. tdata, lowest bit up: event_time_ms[31:0],
  // event_sensor_id[7:0], last_distance_cm[12:0], miss_count[15:0],
  // last_valid_time_ms[31:0], offline. tuser, lowest bit up: sampled, fired.
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [dpt_pkg::OutDataW-1:0]  out_tdata,
  output      logic [dpt_pkg::OutUserW-1:0]  out_tuser,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic [dpt_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [dpt_pkg::CfgDataW-1:0]  cfg_wdata
);
  import dpt_pkg::*;

  // Configuration registers.
  logic [ThrW-1:0]  near_r;
  logic [ThrW-1:0]  far_r;
  logic [TimeW-1:0] period_r;
  logic [TimeW-1:0] cooldown_r;
  logic [IdW-1:0]   sensor_id_r;
  logic [TimeW-1:0] silence_r;
  logic [MissW-1:0] miss_limit_r;

  // Input register stage.
  logic             s1_valid_r;
  logic [TimeW-1:0] s1_now_r;
  logic [DistW-1:0] s1_dist_r;

  // Detector state.
  logic [TimeW-1:0] next_sample_r, next_sample_nxt;
  logic [TimeW-1:0] last_fire_r, last_fire_nxt;
  logic [DistW-1:0] last_reading_r, last_reading_nxt;
  logic             present_r, present_nxt;
  logic [MissW-1:0] miss_r, miss_nxt;
  logic [TimeW-1:0] last_valid_r, last_valid_nxt;

  // Result register stage.
  logic             out_valid_r;
  result_data_t     out_data_r, out_data_nxt;
  result_user_t     out_user_r, out_user_nxt;

  logic             out_free;
  logic             s1_adv;
  logic [TimeW-1:0] due_diff;
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] silence_diff;
  logic             due;
  logic             fired;
  logic             miss_off;
  logic             silence_off;

  // The result register is free when empty or being taken this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // Wrapping signed time difference: due when its sign bit is clear or next_sample_r is zero.
  assign due_diff = s1_now_r - next_sample_r;
  assign due      = (next_sample_r == '0) || !due_diff[TimeW-1];
  assign elapsed  = s1_now_r - last_fire_r;

  always_comb begin
    next_sample_nxt  = next_sample_r;
    last_fire_nxt    = last_fire_r;
    last_reading_nxt = last_reading_r;
    present_nxt      = present_r;
    miss_nxt         = miss_r;
    last_valid_nxt   = last_valid_r;
    fired            = 1'b0;
    if (due) begin
      next_sample_nxt  = s1_now_r + period_r;
      last_reading_nxt = s1_dist_r;
      if (s1_dist_r[DistW-1]) begin
        // No echo: count it, holding at the saturation point.
        if (miss_r != MissMax) begin
          miss_nxt = miss_r + 1'b1;
        end
      end else begin
        miss_nxt       = '0;
        last_valid_nxt = s1_now_r;
        if (!present_r) begin
          if (s1_dist_r[ThrW-1:0] <= near_r) begin
            present_nxt = 1'b1;
            if (elapsed >= cooldown_r) begin
              last_fire_nxt = s1_now_r;
              fired         = 1'b1;
            end
          end
        end else if (s1_dist_r[ThrW-1:0] >= far_r) begin
          present_nxt = 1'b0;
        end
      end
    end
  end

  // Offline status is judged on the state after this item.
  assign silence_diff = s1_now_r - last_valid_nxt - silence_r;
  assign silence_off  = (silence_r != '0) && !silence_diff[TimeW-1];
  assign miss_off     = (miss_limit_r != '0) && (miss_nxt >= miss_limit_r);

  always_comb begin
    out_data_nxt.event_time_ms      = fired ? s1_now_r : '0;
    out_data_nxt.event_sensor_id    = fired ? sensor_id_r : '0;
    out_data_nxt.last_distance_cm   = last_reading_nxt;
    out_data_nxt.miss_count         = miss_nxt;
    out_data_nxt.last_valid_time_ms = last_valid_nxt;
    out_data_nxt.offline            = miss_off || silence_off;
    out_user_nxt.sampled            = due;
    out_user_nxt.fired              = fired;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r       <= NearReset;
      far_r        <= FarReset;
      period_r     <= PeriodReset;
      cooldown_r   <= CooldownReset;
      sensor_id_r  <= '0;
      silence_r    <= '0;
      miss_limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NEAR_THRESHOLD:  near_r       <= cfg_wdata[ThrW-1:0];
        REG_FAR_THRESHOLD:   far_r        <= cfg_wdata[ThrW-1:0];
        REG_SAMPLE_PERIOD:   period_r     <= cfg_wdata[TimeW-1:0];
        REG_COOLDOWN:        cooldown_r   <= cfg_wdata[TimeW-1:0];
        REG_SENSOR_ID:       sensor_id_r  <= cfg_wdata[IdW-1:0];
        REG_OFFLINE_SILENCE: silence_r    <= cfg_wdata[TimeW-1:0];
        REG_OFFLINE_MISSES:  miss_limit_r <= cfg_wdata[MissW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it can pass its current transfer on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_now_r  <= in_tdata[TimeW-1:0];
      s1_dist_r <= in_tdata[TimeW+DistW-1:TimeW];
    end
  end

  // Detector state and result register advance together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_sample_r  <= '0;
      last_fire_r    <= '0;
      last_reading_r <= NoReading;
      present_r      <= 1'b0;
      miss_r         <= '0;
      last_valid_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (s1_adv) begin
        next_sample_r  <= next_sample_nxt;
        last_fire_r    <= last_fire_nxt;
        last_reading_r <= last_reading_nxt;
        present_r      <= present_nxt;
        miss_r         <= miss_nxt;
        last_valid_r   <= last_valid_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - $bits(result_data_t)){1'b0}}, out_data_r};
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // A fired event always comes from a consumed valid reading.
  a_fire_is_valid_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r.fired |->
      out_user_r.sampled && (out_data_r.miss_count == '0) &&
      (out_data_r.last_valid_time_ms == out_data_r.event_time_ms))
    else $error("fired result without a matching valid sample");

  // The missed-echo count only clears or steps up by one.
  a_miss_steps: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (miss_r != $past(miss_r)) |->
      (miss_r == '0) || (miss_r == $past(miss_r) + 1'b1))
    else $error("missed-echo count jumped");

  // A stalled input register keeps its transfer.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_now_r) && $stable(s1_dist_r))
    else $error("input register lost a stalled transfer");

  // State moves only when a transfer passes into the result register.
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(s1_adv) |->
      $stable(next_sample_r) && $stable(present_r) && $stable(last_fire_r))
    else $error("detector state changed without a transfer");
`endif

endmodule : distance_presence_trigger_top
`default_nettype wire
